// ----- hdl/pgbw_pkg.sv -----
// ----------------------------------------------------------------------------
// pgbw_pkg
// Shared types, codes and the gamma 1.8 lookup table of the bit-plane writer.
// ----------------------------------------------------------------------------
`default_nettype none

package pgbw_pkg;

  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned GAMMA_W     = 14;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned BRIGHT_W    = 9;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned MX_W        = 7;
  localparam int unsigned MY_W        = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BRIGHT = 1'b1;

  typedef enum logic [1:0] {
    FMT_RGB888      = 2'd0,
    FMT_RGB565_SWAP = 2'd1,
    FMT_RGB332      = 2'd2,
    FMT_RESERVED    = 2'd3
  } pix_fmt_e;

  typedef struct packed {
    pix_fmt_e              fmt;
    logic [BRIGHT_W-1:0]   bright;
  } cfg_t;

  // One classified pixel, ready to be spread over the bit planes
  typedef struct packed {
    logic [GAMMA_W-1:0] gr;
    logic [GAMMA_W-1:0] gg;
    logic [GAMMA_W-1:0] gb;
    logic [ADDR_W-1:0]  base;
  } job_t;

  typedef logic [GAMMA_W-1:0] gamma_lut_t [256];

  // Round half up of 16383 * (v/255)^1.8: largest n with
  // (2n-1)^5 * 255^9 <= 32 * 16383^5 * v^9. Evaluated at elaboration only.
  function automatic logic [GAMMA_W-1:0] gamma_entry(int unsigned v);
    logic [191:0] rhs;
    logic [191:0] lhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    int           i;
    rhs = 192'd32;
    for (i = 0; i < 5; i++) rhs = rhs * 192'd16383;
    for (i = 0; i < 9; i++) rhs = rhs * 192'(v);
    lo = 0;
    hi = 16383;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 192'd1;
      for (i = 0; i < 5; i++) lhs = lhs * 192'(2 * mid - 1);
      for (i = 0; i < 9; i++) lhs = lhs * 192'd255;
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return GAMMA_W'(lo);
  endfunction

  function automatic gamma_lut_t build_gamma_lut();
    gamma_lut_t t;
    int         v;
    for (v = 0; v < 256; v++) t[v] = gamma_entry(v);
    return t;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

`default_nettype wire

// ----- hdl/pgbw_front.sv -----
// ----------------------------------------------------------------------------
// pgbw_front
// Accepts pixels, drops off-panel ones and those in the reserved format, unpacks and
// scales the channels, then maps them through the gamma table and forms the write base address.
// ----------------------------------------------------------------------------
`default_nettype none

module pgbw_front
  import pgbw_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 53,
  parameter int unsigned PANEL_HEIGHT = 11,
  parameter int unsigned PLANE_COUNT  = 14,
  parameter int unsigned PLANE_BYTES  = 60
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               push_i,
  output      logic               full_o,
  input  wire logic signed [7:0]  pixel_x_i,
  input  wire logic signed [7:0]  pixel_y_i,
  input  wire logic [23:0]        colour_word_i,
  output      logic               job_valid_o,
  input  wire logic               job_ready_i,
  output      job_t               job_o
);

  localparam logic [ADDR_W-1:0] RowBytes = ADDR_W'(PLANE_COUNT * PLANE_BYTES);

  logic                a_valid_q, a_valid_d;
  logic                a_ready;
  logic                in_ok;
  logic [CHAN_W-1:0]   r, g, b;
  logic [15:0]         c565;
  logic [BRIGHT_W+CHAN_W-1:0] pr, pg, pb;
  logic [CHAN_W-1:0]   sr_q, sg_q, sb_q;
  logic [MX_W-1:0]     mx_q;
  logic [MY_W-1:0]     my_q;

  assign a_ready = !a_valid_q || job_ready_i;
  assign full_o  = !a_ready;

  // Unpack the colour word into three 8-bit channels
  always_comb begin
    c565 = {colour_word_i[7:0], colour_word_i[15:8]};
    r    = '0;
    g    = '0;
    b    = '0;
    unique case (cfg_i.fmt)
      FMT_RGB888: begin
        r = colour_word_i[23:16];
        g = colour_word_i[15:8];
        b = colour_word_i[7:0];
      end
      FMT_RGB565_SWAP: begin
        r = {c565[15:11], 3'b000};
        g = {c565[10:5], 2'b00};
        b = {c565[4:0], 3'b000};
      end
      FMT_RGB332: begin
        r = {colour_word_i[7:5], 5'b00000};
        g = {colour_word_i[4:2], 5'b00000};
        b = {colour_word_i[1:0], 6'b000000};
      end
      FMT_RESERVED: begin
        r = '0;
      end
      default: begin
        r = '0;
      end
    endcase
  end

  always_comb begin
    in_ok = !pixel_x_i[7] && (pixel_x_i[6:0] < MX_W'(PANEL_WIDTH))
         && !pixel_y_i[7] && (pixel_y_i[6:0] < 7'(PANEL_HEIGHT))
         && (cfg_i.fmt != FMT_RESERVED);
    pr = BRIGHT_W'(0) + r * cfg_i.bright;
    pg = BRIGHT_W'(0) + g * cfg_i.bright;
    pb = BRIGHT_W'(0) + b * cfg_i.bright;
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (a_ready) begin
      a_valid_d = push_i && in_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  // Hold scaled channels and mirrored coordinates
  always_ff @(posedge clk_i) begin
    if (a_ready && push_i) begin
      sr_q <= pr[CHAN_W+7:8];
      sg_q <= pg[CHAN_W+7:8];
      sb_q <= pb[CHAN_W+7:8];
      mx_q <= MX_W'(PANEL_WIDTH - 1) - pixel_x_i[6:0];
      my_q <= MY_W'(PANEL_HEIGHT - 1) - pixel_y_i[MY_W-1:0];
    end
  end

  always_comb begin
    job_valid_o = a_valid_q;
    job_o.gr    = GAMMA_LUT[sr_q];
    job_o.gg    = GAMMA_LUT[sg_q];
    job_o.gb    = GAMMA_LUT[sb_q];
    job_o.base  = ADDR_W'(my_q * RowBytes) + ADDR_W'(mx_q) + ADDR_W'(1);
  end

endmodule

`default_nettype wire

// ----- hdl/pgbw_queue.sv -----
// ----------------------------------------------------------------------------
// pgbw_queue
// Short job queue between the pixel front end and the plane writer.
// ----------------------------------------------------------------------------
`default_nettype none

module pgbw_queue
  import pgbw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output      logic wr_ready_o,
  input  wire job_t wr_data_i,
  output      logic rd_valid_o,
  input  wire logic rd_ready_i,
  output      job_t rd_data_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign wr_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pgbw_back.sv -----
// ----------------------------------------------------------------------------
// pgbw_back
// Walks the bit planes of one job into an output register, one byte write per
// cycle while the output register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module pgbw_back
  import pgbw_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 14,
  parameter int unsigned PLANE_BYTES = 60
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  output      logic              job_pop_o,
  input  wire job_t              job_i,
  output      logic              empty_o,
  input  wire logic              pop_i,
  output      logic [ADDR_W-1:0] write_address_o,
  output      logic [2:0]        write_byte_o,
  output      logic              last_write_o
);

  localparam int unsigned CntW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  logic              busy_q, busy_d;
  job_t              job_q;
  logic [CntW-1:0]   cnt_q;
  logic [ADDR_W-1:0] addr_q;
  logic              out_valid_q, out_valid_d;
  logic              out_ready, take, is_last, load;
  logic [GAMMA_W-1:0] sh_r, sh_g, sh_b;

  assign out_ready = !out_valid_q || pop_i;
  assign take      = busy_q && out_ready;
  assign is_last   = cnt_q == CntW'(PLANE_COUNT - 1);
  assign load      = job_valid_i && (!busy_q || (take && is_last));
  assign job_pop_o = load;
  assign empty_o   = !out_valid_q;

  always_comb begin
    sh_r = job_q.gr >> cnt_q;
    sh_g = job_q.gg >> cnt_q;
    sh_b = job_q.gb >> cnt_q;
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
    end else if (take && is_last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance the plane walk and load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q  <= job_i;
      cnt_q  <= '0;
      addr_q <= job_i.base;
    end else if (take) begin
      cnt_q  <= cnt_q + CntW'(1);
      addr_q <= addr_q + ADDR_W'(PLANE_BYTES);
    end
    if (take) begin
      write_address_o <= addr_q;
      write_byte_o    <= {sh_r[0], sh_g[0], sh_b[0]};
      last_write_o    <= is_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pixel_gamma_bitplane_writer_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_gamma_bitplane_writer_unit
// Converts one pixel into PLANE_COUNT gamma-corrected bit-plane byte writes.
// ----------------------------------------------------------------------------
// Path: a pixel is registered in the front end, written into the job queue, loaded
//   into the plane writer and then registered on the result ports.
// Throughput: one byte write per cycle while the result register is empty or popped;
//   new pixels queue while a job is walked; off-panel pixels are dropped at intake.
// Reset: format RGB888, brightness 256 (unity), job queue and outputs empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_gamma_bitplane_writer_unit
  import pgbw_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 53,
  parameter int unsigned PANEL_HEIGHT = 11,
  parameter int unsigned PLANE_COUNT  = 14,
  parameter int unsigned PLANE_BYTES  = 60
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel side
  input  wire logic                  push,
  output      logic                  full,
  input  wire logic signed [7:0]     pixel_x_i,
  input  wire logic signed [7:0]     pixel_y_i,
  input  wire logic [23:0]           colour_word_i,
  // write side
  output      logic                  empty,
  input  wire logic                  pop,
  output      logic [ADDR_W-1:0]     write_address_o,
  output      logic [2:0]            write_byte_o,
  output      logic                  last_write_o
);

  cfg_t cfg_q, cfg_d;

  // Front end to queue, queue to writer
  logic fr_valid, fr_ready;
  job_t fr_job;
  logic bk_valid, bk_pop;
  job_t bk_job;

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce this
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_FORMAT: cfg_d.fmt    = pix_fmt_e'(cfg_data_i[1:0]);
        CFG_IDX_BRIGHT: cfg_d.bright = cfg_data_i[BRIGHT_W-1:0];
        default:        cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= FMT_RGB888;
      cfg_q.bright <= BRIGHT_W'(256);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Classify the pixel, scale and gamma-map its channels
  pgbw_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .PLANE_COUNT  (PLANE_COUNT),
    .PLANE_BYTES  (PLANE_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .colour_word_i (colour_word_i),
    .job_valid_o   (fr_valid),
    .job_ready_i   (fr_ready),
    .job_o         (fr_job)
  );

  // Decouple pixel intake from the plane walk
  pgbw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_job),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_pop),
    .rd_data_o  (bk_job)
  );

  // Emit one write transaction per bit plane
  pgbw_back #(
    .PLANE_COUNT (PLANE_COUNT),
    .PLANE_BYTES (PLANE_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (bk_valid),
    .job_pop_o       (bk_pop),
    .job_i           (bk_job),
    .empty_o         (empty),
    .pop_i           (pop),
    .write_address_o (write_address_o),
    .write_byte_o    (write_byte_o),
    .last_write_o    (last_write_o)
  );

endmodule

`default_nettype wire
